// ===== sv/mtdq_pkg.sv =====
// ---------------------------------------------------------------------------
// mtdq_pkg: shared types and constants for the timer deadline queue
// Operation codes, sequencer states and default sizes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtdq_pkg;

	localparam int TIMERS_DEF        = 8;
	localparam int TIME_BITS_DEF     = 48;
	localparam int INTERVAL_BITS_DEF = 16;

	localparam int NOW_BITS   = 48;
	localparam int INDEX_BITS = 3;
	localparam int IV_BITS    = 16;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_TICK  = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OP,
		ST_SCAN,
		ST_FIRE,
		ST_FIRE_UPD
	} state_t;

endpackage

`default_nettype wire

// ===== sv/mtdq_ram.sv =====
// ---------------------------------------------------------------------------
// mtdq_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/multi_timer_deadline_queue.sv =====
// ---------------------------------------------------------------------------
// multi_timer_deadline_queue: bank of one-shot / periodic timers
// Start, stop and query pass through one busy state, with the result strobe in the cycle after it.
// A tick first scans the timers (one RAM read per timer), then visits start-order
// positions (at most 2*TIMERS, due-now then due-next), firing each due timer, and
// ends with a closing check; one strobe per firing, or one non-firing strobe if none.
// The receiver cannot stall; every strobe is a one-cycle result.
// Reset clears time and all active flags; the deadline RAM keeps its contents.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_timer_deadline_queue #(
	parameter int TIMERS        = mtdq_pkg::TIMERS_DEF,
	parameter int TIME_BITS     = mtdq_pkg::TIME_BITS_DEF,
	parameter int INTERVAL_BITS = mtdq_pkg::INTERVAL_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [1:0]                        operation,
	input  wire logic [mtdq_pkg::INDEX_BITS-1:0]   timer_index,
	input  wire logic [mtdq_pkg::IV_BITS-1:0]      interval_ms,
	input  wire logic                              single_shot,
	output logic                                   done,
	output logic                                   fired,
	output logic      [mtdq_pkg::INDEX_BITS-1:0]   timer_index_res,
	output logic                                   active,
	output logic      [mtdq_pkg::NOW_BITS-1:0]     now_ms,
	output logic                                   last
);

	localparam int IW = $clog2(TIMERS);
	localparam int CW = $clog2(TIMERS + 1);
	localparam int DW = TIME_BITS + INTERVAL_BITS + 1;

	mtdq_pkg::state_t state_q, state_d;

	mtdq_pkg::op_t                  op_q;
	logic [mtdq_pkg::INDEX_BITS-1:0] idx_q;
	logic [INTERVAL_BITS-1:0]       iv_q;
	logic                           one_q;

	logic [TIME_BITS-1:0] now_q;
	logic [TIMERS-1:0]    act_q, act_d;
	logic [IW-1:0]        rank_q [TIMERS];
	logic [IW-1:0]        rank_d [TIMERS];
	logic [IW-1:0]        ord_q  [TIMERS];
	logic [TIMERS-1:0]    due0_q, due1_q;

	logic [CW-1:0] scan_q;
	logic          pend_s1;
	logic [IW-1:0] pidx_s1;

	logic [IW-1:0] pos_q;
	logic          cls_q;
	logic [CW-1:0] nsnap_q, ndue_q, nfired_q;
	logic [IW-1:0] t_q;

	logic                            done_q, fired_q, actout_q, last_q;
	logic [mtdq_pkg::INDEX_BITS-1:0] tidx_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [DW-1:0] ram_wdata, ram_rdata;

	logic [TIME_BITS-1:0]     rd_dl;
	logic [INTERVAL_BITS-1:0] rd_pr;
	logic                     rd_os;

	logic [6:0]           idx_wide;
	logic                 idx_ok;
	logic [IW-1:0]        cur;
	logic [CW-1:0]        cnt_act;
	logic [IW-1:0]        cur_rank;
	logic                 cur_act;
	logic [IW-1:0]        ord_t;
	logic                 ord_due;
	logic                 pos_ok;
	logic [TIME_BITS-1:0] ahead;
	logic [TIME_BITS-1:0] fire_dl;
	logic [TIME_BITS-1:0] start_dl;
	logic [63:0]          now_w;

	logic                            det_en, att_en;
	logic                            emit, emit_fired, emit_act, emit_last;
	logic [mtdq_pkg::INDEX_BITS-1:0] emit_idx;

	mtdq_ram #(
		.WIDTH(DW),
		.DEPTH(TIMERS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_dl = ram_rdata[DW-1 -: TIME_BITS];
	assign rd_pr = ram_rdata[INTERVAL_BITS:1];
	assign rd_os = ram_rdata[0];

	assign idx_wide = 7'(idx_q);
	assign idx_ok   = idx_wide < 7'(TIMERS);

	always_comb begin
		case (state_q)
			mtdq_pkg::ST_SCAN:     cur = pidx_s1;
			mtdq_pkg::ST_FIRE_UPD: cur = t_q;
			default:               cur = IW'(idx_q);
		endcase
	end

	assign cnt_act  = CW'($countones(act_q));
	assign cur_rank = rank_q[cur];
	assign cur_act  = act_q[cur];
	assign ord_t    = ord_q[pos_q];
	assign ord_due  = cls_q ? due1_q[ord_t] : due0_q[ord_t];
	assign pos_ok   = CW'(pos_q) < nsnap_q;
	assign ahead    = rd_dl - now_q;
	assign fire_dl  = (rd_pr == '0) ? now_q : rd_dl + TIME_BITS'(rd_pr);
	assign start_dl = now_q + TIME_BITS'(iv_q);

	// sequencer
	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_waddr  = cur;
		ram_wdata  = '0;
		ram_raddr  = '0;
		det_en     = 1'b0;
		att_en     = 1'b0;
		emit       = 1'b0;
		emit_fired = 1'b0;
		emit_idx   = idx_q;
		emit_act   = 1'b0;
		emit_last  = 1'b1;
		case (state_q)
			mtdq_pkg::ST_IDLE: begin
				if (start) begin
					if (mtdq_pkg::op_t'(operation) == mtdq_pkg::OP_TICK) begin
						state_d = mtdq_pkg::ST_SCAN;
					end else begin
						state_d = mtdq_pkg::ST_OP;
					end
				end
			end
			mtdq_pkg::ST_OP: begin
				emit    = 1'b1;
				state_d = mtdq_pkg::ST_IDLE;
				case (op_q)
					mtdq_pkg::OP_START: begin
						ram_we    = idx_ok;
						ram_wdata = {start_dl, iv_q, one_q};
						det_en    = idx_ok;
						att_en    = idx_ok;
						emit_act  = idx_ok;
					end
					mtdq_pkg::OP_STOP: begin
						det_en = idx_ok;
					end
					mtdq_pkg::OP_QUERY: begin
						emit_act = idx_ok && cur_act;
					end
					default: begin
					end
				endcase
			end
			mtdq_pkg::ST_SCAN: begin
				if (scan_q < CW'(TIMERS)) begin
					ram_raddr = scan_q[IW-1:0];
				end else if (!pend_s1) begin
					state_d = mtdq_pkg::ST_FIRE;
				end
			end
			mtdq_pkg::ST_FIRE: begin
				if (ndue_q == '0) begin
					emit     = 1'b1;
					emit_idx = '0;
					state_d  = mtdq_pkg::ST_IDLE;
				end else if (nfired_q == ndue_q) begin
					state_d = mtdq_pkg::ST_IDLE;
				end else if (pos_ok && ord_due) begin
					ram_raddr = ord_t;
					state_d   = mtdq_pkg::ST_FIRE_UPD;
				end
			end
			mtdq_pkg::ST_FIRE_UPD: begin
				emit       = 1'b1;
				emit_fired = 1'b1;
				emit_idx   = mtdq_pkg::INDEX_BITS'(t_q);
				emit_act   = !rd_os;
				emit_last  = CW'(nfired_q + CW'(1)) == ndue_q;
				det_en     = 1'b1;
				att_en     = !rd_os;
				ram_we     = !rd_os;
				ram_wdata  = {fire_dl, rd_pr, rd_os};
				state_d    = mtdq_pkg::ST_FIRE;
			end
			default: begin
				state_d = mtdq_pkg::ST_IDLE;
			end
		endcase
	end

	// start-order ranks: removal closes the gap, a (re)start goes to the back
	always_comb begin
		rank_d = rank_q;
		act_d  = act_q;
		if (det_en && cur_act) begin
			for (int i = 0; i < TIMERS; i++) begin
				if (act_q[i] && rank_q[i] > cur_rank) begin
					rank_d[i] = rank_q[i] - IW'(1);
				end
			end
		end
		if (att_en) begin
			rank_d[cur] = IW'(cnt_act - CW'(cur_act));
			act_d[cur]  = 1'b1;
		end else if (det_en) begin
			act_d[cur] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mtdq_pkg::ST_IDLE;
			now_q    <= '0;
			act_q    <= '0;
			done_q   <= 1'b0;
			scan_q   <= '0;
			pend_s1  <= 1'b0;
			pos_q    <= '0;
			cls_q    <= 1'b0;
			nsnap_q  <= '0;
			ndue_q   <= '0;
			nfired_q <= '0;
		end else begin
			state_q <= state_d;
			act_q   <= act_d;
			done_q  <= emit;
			case (state_q)
				mtdq_pkg::ST_IDLE: begin
					scan_q  <= '0;
					pend_s1 <= 1'b0;
				end
				mtdq_pkg::ST_SCAN: begin
					if (scan_q < CW'(TIMERS)) begin
						scan_q  <= scan_q + CW'(1);
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (state_d == mtdq_pkg::ST_FIRE) begin
						now_q    <= now_q + TIME_BITS'(1);
						pos_q    <= '0;
						cls_q    <= 1'b0;
						nsnap_q  <= cnt_act;
						ndue_q   <= CW'($countones(due0_q | due1_q));
						nfired_q <= '0;
					end
				end
				mtdq_pkg::ST_FIRE: begin
					if (pos_q == IW'(TIMERS - 1)) begin
						pos_q <= '0;
						cls_q <= 1'b1;
					end else begin
						pos_q <= pos_q + IW'(1);
					end
				end
				mtdq_pkg::ST_FIRE_UPD: begin
					nfired_q <= nfired_q + CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rank_q <= rank_d;
		if (state_q == mtdq_pkg::ST_IDLE && start) begin
			op_q  <= mtdq_pkg::op_t'(operation);
			idx_q <= timer_index;
			iv_q  <= INTERVAL_BITS'(interval_ms);
			one_q <= single_shot;
		end
		if (state_q == mtdq_pkg::ST_SCAN) begin
			pidx_s1 <= scan_q[IW-1:0];
			if (pend_s1) begin
				due0_q[pidx_s1] <= cur_act && (ahead == '0);
				due1_q[pidx_s1] <= cur_act && (ahead == TIME_BITS'(1));
				if (cur_act) begin
					ord_q[cur_rank] <= pidx_s1;
				end
			end
		end
		if (state_q == mtdq_pkg::ST_FIRE) begin
			t_q <= ord_t;
		end
		if (emit) begin
			fired_q  <= emit_fired;
			tidx_q   <= emit_idx;
			actout_q <= emit_act;
			last_q   <= emit_last;
		end
	end

	assign now_w           = 64'(now_q);
	assign busy            = state_q != mtdq_pkg::ST_IDLE;
	assign done            = done_q;
	assign fired           = fired_q;
	assign timer_index_res = tidx_q;
	assign active          = actout_q;
	assign now_ms          = now_w[mtdq_pkg::NOW_BITS-1:0];
	assign last            = last_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |=> !done)
		else $error("result strobe right after a final result");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> busy)
		else $error("non-final result while idle");

	a_fire_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mtdq_pkg::ST_FIRE_UPD |-> act_q[t_q])
		else $error("firing a timer that is not active");

endmodule

`default_nettype wire

// ===== dv/multi_timer_deadline_queue_test.sv =====
// ---------------------------------------------------------------------------
// multi_timer_deadline_queue_test: self-checking bench for the timer queue
// Drives start, stop, query and tick requests with random gaps. A scoreboard
// keeps its own copy of the timer bank, predicts every result strobe
// (firing order by deadline, then by start order) and checks each field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_timer_deadline_queue_test;

	localparam int NT             = mtdq_pkg::TIMERS_DEF;
	localparam int IXB            = mtdq_pkg::INDEX_BITS;
	localparam int NWB            = mtdq_pkg::NOW_BITS;
	localparam int IVB            = mtdq_pkg::IV_BITS;
	localparam int RANDOM_ITEMS   = 225;
	localparam int DRAIN_CYCLES   = 60;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		bit           fired;
		bit [IXB-1:0] index;
		bit           running;
		bit [NWB-1:0] stamp;
		bit           tail;
	} result_t;

	class timer_bank_scoreboard;
		bit [NWB-1:0] now_t;
		bit           act    [NT];
		bit [NWB-1:0] due    [NT];
		bit [IVB-1:0] period [NT];
		bit           once   [NT];
		int unsigned  rank   [NT];
		result_t      pending_results[$];
		int           errors;

		function new();
			now_t  = '0;
			errors = 0;
			foreach (act[i]) begin
				act[i]    = 1'b0;
				due[i]    = '0;
				period[i] = '0;
				once[i]   = 1'b0;
				rank[i]   = 0;
			end
		endfunction

		function void expect_result(result_t r);
			pending_results.insert(pending_results.size(), r);
		endfunction

		function result_t take_expected();
			result_t r;
			r = pending_results[0];
			pending_results.delete(0);
			return r;
		endfunction

		function void detach(int t);
			if (!act[t])
				return;
			for (int i = 0; i < NT; i++)
				if (act[i] && rank[i] > rank[t])
					rank[i]--;
			act[t] = 1'b0;
		endfunction

		function void attach(int t, bit [NWB-1:0] deadline);
			int unsigned n;
			detach(t);
			n = 0;
			for (int i = 0; i < NT; i++)
				if (act[i])
					n++;
			rank[t] = n;
			due[t]  = deadline;
			act[t]  = 1'b1;
		endfunction

		function void advance_tick();
			bit [NWB-1:0] base;
			bit [NWB-1:0] target;
			bit [NWB-1:0] ahead;
			bit [NWB-1:0] best_ahead;
			bit           seen [NT];
			int           best;
			int           count;
			bit           searching;
			result_t      r;
			base   = now_t;
			target = base + 1'b1;
			foreach (seen[i])
				seen[i] = 1'b0;
			count     = 0;
			searching = 1'b1;
			while (searching) begin
				best       = -1;
				best_ahead = '0;
				for (int i = 0; i < NT; i++) begin
					if (act[i] && !seen[i]) begin
						ahead = due[i] - base;
						if (ahead <= 1 && (best < 0 || ahead < best_ahead ||
						    (ahead == best_ahead && rank[i] < rank[best]))) begin
							best       = i;
							best_ahead = ahead;
						end
					end
				end
				if (best < 0) begin
					searching = 1'b0;
				end else begin
					seen[best] = 1'b1;
					if (once[best])
						detach(best);
					else if (period[best] == '0)
						attach(best, target);
					else
						attach(best, due[best] + period[best]);
					r.fired   = 1'b1;
					r.index   = IXB'(best);
					r.running = act[best];
					r.stamp   = target;
					r.tail    = 1'b0;
					expect_result(r);
					count++;
				end
			end
			now_t = target;
			if (count == 0) begin
				r = '{fired: 1'b0, index: '0, running: 1'b0, stamp: now_t, tail: 1'b1};
				expect_result(r);
			end else begin
				pending_results[pending_results.size() - 1].tail = 1'b1;
			end
		endfunction

		function void note_request(mtdq_pkg::op_t op, bit [IXB-1:0] idx,
		                           bit [IVB-1:0] iv, bit ss);
			result_t r;
			if (op == mtdq_pkg::OP_TICK) begin
				advance_tick();
				return;
			end
			if (op == mtdq_pkg::OP_START) begin
				period[idx] = iv;
				once[idx]   = ss;
				attach(idx, now_t + iv);
			end else if (op == mtdq_pkg::OP_STOP) begin
				detach(idx);
			end
			r = '{fired: 1'b0, index: idx, running: act[idx], stamp: now_t, tail: 1'b1};
			expect_result(r);
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (pending_results.size() == 0) begin
				$error("unexpected result: index %0d fired %0d", got.index, got.fired);
				errors++;
				return;
			end
			exp = take_expected();
			if (got.fired !== exp.fired) begin
				$error("fired: expected %0d, actual %0d", exp.fired, got.fired);
				errors++;
			end
			if (got.index !== exp.index) begin
				$error("timer_index_res: expected %0d, actual %0d", exp.index, got.index);
				errors++;
			end
			if (got.running !== exp.running) begin
				$error("active: expected %0d, actual %0d", exp.running, got.running);
				errors++;
			end
			if (got.stamp !== exp.stamp) begin
				$error("now_ms: expected %0d, actual %0d", exp.stamp, got.stamp);
				errors++;
			end
			if (got.tail !== exp.tail) begin
				$error("last: expected %0d, actual %0d", exp.tail, got.tail);
				errors++;
			end
		endfunction
	endclass

	logic           clk         = 1'b0;
	logic           arst_n      = 1'b0;
	logic           start       = 1'b0;
	logic [1:0]     operation   = 2'd0;
	logic [IXB-1:0] timer_index = '0;
	logic [IVB-1:0] interval_ms = '0;
	logic           single_shot = 1'b0;
	logic           busy;
	logic           done;
	logic           fired;
	logic [IXB-1:0] timer_index_res;
	logic           active;
	logic [NWB-1:0] now_ms;
	logic           last;

	timer_bank_scoreboard book;
	int                   no_gap_left = 0;
	int                   idle_cycles = 0;

	multi_timer_deadline_queue u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.timer_index     (timer_index),
		.interval_ms     (interval_ms),
		.single_shot     (single_shot),
		.done            (done),
		.fired           (fired),
		.timer_index_res (timer_index_res),
		.active          (active),
		.now_ms          (now_ms),
		.last            (last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			book.check_result('{fired: fired, index: timer_index_res, running: active,
			                    stamp: now_ms, tail: last});
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[multi_timer_deadline_queue] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_request(mtdq_pkg::op_t op, bit [IXB-1:0] idx,
	                            bit [IVB-1:0] iv, bit ss);
		int gap;
		if (no_gap_left > 0) begin
			gap = 0;
			no_gap_left--;
		end else begin
			gap = $urandom_range(0, 8);
			if ($urandom_range(0, 19) == 0)
				no_gap_left = $urandom_range(8, 20);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		operation   <= op;
		timer_index <= idx;
		interval_ms <= iv;
		single_shot <= ss;
		do
			@(posedge clk);
		while (busy);
		book.note_request(op, idx, iv, ss);
	endtask

	function automatic bit [IVB-1:0] pick_interval();
		case ($urandom_range(0, 9))
			0:       return IVB'($urandom);
			1:       return $urandom_range(0, 1) ? '1 : '0;
			default: return IVB'($urandom_range(0, 6));
		endcase
	endfunction

	task automatic run_directed();
		send_request(mtdq_pkg::OP_TICK,  3'd0, 16'd0,     1'b0);
		send_request(mtdq_pkg::OP_QUERY, 3'd0, 16'd0,     1'b0);
		send_request(mtdq_pkg::OP_START, 3'd7, 16'hFFFF,  1'b1);
		send_request(mtdq_pkg::OP_START, 3'd0, 16'd0,     1'b0);
		send_request(mtdq_pkg::OP_START, 3'd3, 16'd2,     1'b1);
		send_request(mtdq_pkg::OP_START, 3'd5, 16'd2,     1'b0);
		send_request(mtdq_pkg::OP_START, 3'd1, 16'd1,     1'b0);
		send_request(mtdq_pkg::OP_TICK,  3'd7, 16'hFFFF,  1'b1);
		send_request(mtdq_pkg::OP_TICK,  3'd0, 16'd0,     1'b0);
		send_request(mtdq_pkg::OP_START, 3'd3, 16'd1,     1'b0);
		send_request(mtdq_pkg::OP_QUERY, 3'd3, 16'hFFFF,  1'b1);
		send_request(mtdq_pkg::OP_STOP,  3'd0, 16'd0,     1'b0);
		send_request(mtdq_pkg::OP_QUERY, 3'd0, 16'd0,     1'b0);
		send_request(mtdq_pkg::OP_TICK,  3'd0, 16'd0,     1'b0);
		send_request(mtdq_pkg::OP_START, 3'd2, 16'd0,     1'b1);
		send_request(mtdq_pkg::OP_START, 3'd4, 16'd1,     1'b1);
		send_request(mtdq_pkg::OP_START, 3'd6, 16'd1,     1'b0);
		send_request(mtdq_pkg::OP_START, 3'd0, 16'd1,     1'b0);
		send_request(mtdq_pkg::OP_TICK,  3'd0, 16'd0,     1'b0);
		send_request(mtdq_pkg::OP_STOP,  3'd7, 16'hFFFF,  1'b1);
		send_request(mtdq_pkg::OP_QUERY, 3'd7, 16'd0,     1'b0);
		send_request(mtdq_pkg::OP_STOP,  3'd7, 16'd0,     1'b0);
		send_request(mtdq_pkg::OP_START, 3'd7, 16'hAAAA,  1'b0);
		send_request(mtdq_pkg::OP_START, 3'd7, 16'h5555,  1'b0);
		send_request(mtdq_pkg::OP_TICK,  3'd0, 16'd0,     1'b0);
	endtask

	task automatic run_random();
		int            sent;
		int            pick;
		mtdq_pkg::op_t op;
		bit [IVB-1:0]  burst_iv;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				// load every timer around the same deadline, then tick through it
				burst_iv = IVB'($urandom_range(0, 3));
				for (int i = 0; i < NT; i++) begin
					send_request(mtdq_pkg::OP_START, IXB'(i),
					             burst_iv + IVB'($urandom_range(0, 1)),
					             1'($urandom_range(0, 1)));
					sent++;
				end
				repeat ($urandom_range(1, 5)) begin
					send_request(mtdq_pkg::OP_TICK, IXB'($urandom), IVB'($urandom),
					             1'($urandom));
					sent++;
				end
			end else begin
				pick = $urandom_range(0, 19);
				if (pick < 8)
					op = mtdq_pkg::OP_TICK;
				else if (pick < 14)
					op = mtdq_pkg::OP_START;
				else if (pick < 17)
					op = mtdq_pkg::OP_STOP;
				else
					op = mtdq_pkg::OP_QUERY;
				send_request(op, IXB'($urandom),
				             op == mtdq_pkg::OP_START ? pick_interval() : IVB'($urandom),
				             1'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		book = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		start <= 1'b0;
		while (book.pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.errors == 0 && book.pending_results.size() == 0)
			$display("[multi_timer_deadline_queue] OK");
		else
			$display("[multi_timer_deadline_queue] ERROR");
		$finish;
	end

endmodule

// ===== multi_timer_deadline_queue.f =====
sv/mtdq_pkg.sv
sv/mtdq_ram.sv
sv/multi_timer_deadline_queue.sv
dv/multi_timer_deadline_queue_test.sv
